/* design/activation_with_derivative_macros.svh */
// Assertion macros for the activation unit
`ifndef ACTIVATION_WITH_DERIVATIVE_MACROS_SVH
`define ACTIVATION_WITH_DERIVATIVE_MACROS_SVH

// cond holds -> expr holds in the same cycle
`define AWD_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("activation unit: same-cycle check failed");

// cond holds -> expr holds in the next cycle
`define AWD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("activation unit: next-cycle check failed");

`endif

/* design/awd_pkg.sv */
// Package: widths, kind codes, stage control and lookup tables of the activation unit
package awd_pkg;

   localparam int TABLE_SEGMENTS = 64;   // power of two
   localparam int FRACTION_BITS  = 12;

   localparam int IN_W     = 16;
   localparam int ACT_W    = 16;
   localparam int SLOPE_W  = 13;
   localparam int KIND_W   = 2;
   localparam int STAGES   = 6;

   localparam int SEG_BITS = $clog2(TABLE_SEGMENTS);
   localparam int OFF_BITS = IN_W - SEG_BITS;
   localparam int TAB_W    = FRACTION_BITS + 2;
   localparam int DY_W     = TAB_W + 1;
   localparam int NUM_W    = DY_W + OFF_BITS + 1;
   localparam int MAG_W    = FRACTION_BITS + 1;
   localparam int PROD_W   = 2 * MAG_W;
   localparam int AW       = ((TAB_W > IN_W) ? TAB_W : IN_W) + 1;
   localparam int DW       = (MAG_W > SLOPE_W) ? MAG_W : SLOPE_W;

   localparam int ONE_F     = 1 << FRACTION_BITS;
   localparam int SLOPE_MAX = (1 << SLOPE_W) - 1;
   localparam int ACT_MAX   = (1 << (ACT_W - 1)) - 1;
   localparam int ACT_MIN   = -(1 << (ACT_W - 1));
   localparam int SLOPE_LIM = (ONE_F < SLOPE_MAX) ? ONE_F : SLOPE_MAX;

   localparam int SHIFT_DOWN     = 30 - FRACTION_BITS;
   localparam logic [63:0] ONE30  = 64'd1 << 30;
   localparam logic [63:0] HALF30 = 64'd1 << (SHIFT_DOWN - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_RELU    = 2'd0,
      KIND_SIGMOID = 2'd1,
      KIND_TANH    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } stage_ctrl_type;

   typedef logic [TABLE_SEGMENTS:0][TAB_W-1:0] tab_type;

   // shift-subtract division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-y, y in [0,1], 30 fraction bits
   function automatic logic [63:0] exp_neg30(input logic [63:0] y);
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      term = ONE30;
      pos  = ONE30;
      neg  = '0;
      for (int k = 1; k <= 24; k++) begin
         term = udiv64((term * y) >> 30, 64'(k));
         if (k[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return (pos > neg) ? pos - neg : '0;
   endfunction

   // logistic of xraw / 2^FRACTION_BITS, 30 fraction bits
   function automatic logic [63:0] sig30(input logic signed [63:0] xraw);
      logic [63:0] a;
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] e;
      logic [63:0] em1;
      logic [63:0] s;
      a   = (xraw < 0) ? 64'(-xraw) : 64'(xraw);
      n   = a >> FRACTION_BITS;
      f   = (a & ((64'd1 << FRACTION_BITS) - 64'd1)) << SHIFT_DOWN;
      e   = exp_neg30(f);
      em1 = exp_neg30(ONE30);
      for (logic [63:0] i = '0; (i < n) && (e != '0); i++) begin
         e = (e * em1 + (ONE30 >> 1)) >> 30;
      end
      s = (udiv64(64'd1 << 61, ONE30 + e) + 64'd1) >> 1;
      if (s > ONE30) begin
         s = ONE30;
      end
      return (xraw < 0) ? ONE30 - s : s;
   endfunction

   function automatic logic signed [63:0] breakpoint(input int k);
      return $signed(64'(k) << OFF_BITS) - 64'sd32768;
   endfunction

   function automatic tab_type build_sig();
      tab_type     t;
      logic [63:0] s;
      for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
         s    = sig30(breakpoint(k));
         t[k] = TAB_W'((s + HALF30) >> SHIFT_DOWN);
      end
      return t;
   endfunction

   function automatic tab_type build_tanh();
      tab_type     t;
      logic [63:0] s;
      logic [63:0] v;
      for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
         s    = sig30(breakpoint(k) <<< 1);
         v    = ((s << 1) + HALF30) >> SHIFT_DOWN;
         t[k] = TAB_W'(v - 64'(ONE_F));
      end
      return t;
   endfunction

   localparam tab_type SIG_TABLE  = build_sig();
   localparam tab_type TANH_TABLE = build_tanh();

endpackage

/* design/awd_if.sv */
// Channel interfaces: input item (pre-activation) and result item (activation, slope)
interface awd_req_if import awd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] pre_activation;

   modport source (output valid, output pre_activation, input ready);
   modport sink   (input valid, input pre_activation, output ready);
endinterface

interface awd_rsp_if import awd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ACT_W-1:0] activated;
   logic [SLOPE_W-1:0]      slope;

   modport source (output valid, output activated, output slope, input ready);
   modport sink   (input valid, input activated, input slope, output ready);
endinterface

/* design/awd_datapath.sv */
// Six-stage datapath: table lookup, interpolation, clamp, derivative product, output select
module awd_datapath import awd_pkg::*; (
   input  logic                    clock,
   input  stage_ctrl_type          ctrl,
   input  logic signed [IN_W-1:0]  z_in,
   input  kind_type                kind_in,
   output logic signed [ACT_W-1:0] act_out,
   output logic [SLOPE_W-1:0]      slope_out
);

   localparam logic signed [NUM_W-1:0] POS_BIAS = NUM_W'(1 << (OFF_BITS - 1));
   localparam logic signed [NUM_W-1:0] NEG_BIAS = NUM_W'((1 << (OFF_BITS - 1)) - 1);
   localparam logic signed [DY_W-1:0]  ONE_DY   = DY_W'(ONE_F);
   localparam logic [PROD_W:0]         HALF_P   = (PROD_W + 1)'(ONE_F >> 1);

   // z and kind travel alongside
   logic signed [IN_W-1:0] z_ff    [STAGES-1];
   kind_type               kind_ff [STAGES-1];

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         z_ff[0]    <= z_in;
         kind_ff[0] <= kind_in;
      end
      for (int i = 1; i < STAGES - 1; i++) begin
         if (ctrl.load[i]) begin
            z_ff[i]    <= z_ff[i-1];
            kind_ff[i] <= kind_ff[i-1];
         end
      end
   end

   // stage 0: segment lookup
   logic [IN_W-1:0]         biased;
   logic [SEG_BITS:0]       seg_lo;
   logic [SEG_BITS:0]       seg_hi;
   logic signed [TAB_W-1:0] y_lo;
   logic signed [TAB_W-1:0] y_hi;
   logic signed [TAB_W-1:0] base0_ff;
   logic signed [DY_W-1:0]  dy0_ff;
   logic signed [DY_W-1:0]  dy0_in;
   logic [OFF_BITS-1:0]     off0_ff;

   assign biased = {~z_in[IN_W-1], z_in[IN_W-2:0]};
   assign seg_lo = {1'b0, biased[IN_W-1 -: SEG_BITS]};
   assign seg_hi = seg_lo + 1'b1;

   always_comb begin
      if (kind_in == KIND_TANH) begin
         y_lo = $signed(TANH_TABLE[seg_lo]);
         y_hi = $signed(TANH_TABLE[seg_hi]);
      end else begin
         y_lo = $signed(SIG_TABLE[seg_lo]);
         y_hi = $signed(SIG_TABLE[seg_hi]);
      end
      dy0_in = DY_W'(y_hi) - DY_W'(y_lo);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         base0_ff <= y_lo;
         dy0_ff   <= dy0_in;
         off0_ff  <= biased[OFF_BITS-1:0];
      end
   end

   // stage 1: slope times offset
   logic signed [TAB_W-1:0] base1_ff;
   logic signed [NUM_W-1:0] num1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         base1_ff <= base0_ff;
         num1_ff  <= NUM_W'(dy0_ff) * $signed({1'b0, off0_ff});
      end
   end

   // stage 2: divide by segment length, round half away from zero
   logic signed [NUM_W-1:0] rnd_sum;
   logic signed [NUM_W-1:0] q_full;
   logic signed [TAB_W-1:0] base2_ff;
   logic signed [DY_W-1:0]  q2_ff;

   assign rnd_sum = num1_ff + (num1_ff[NUM_W-1] ? NEG_BIAS : POS_BIAS);
   assign q_full  = rnd_sum >>> OFF_BITS;

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         base2_ff <= base1_ff;
         q2_ff    <= q_full[DY_W-1:0];
      end
   end

   // stage 3: interpolated value, clamp, derivative operands
   logic signed [DY_W-1:0]  y_sum;
   logic signed [DY_W-1:0]  y_clip;
   logic signed [DY_W-1:0]  y_low;
   logic signed [DY_W-1:0]  y_mag;
   logic signed [DY_W-1:0]  y_rest;
   logic [MAG_W-1:0]        opa3_in;
   logic [MAG_W-1:0]        opb3_in;
   logic signed [TAB_W-1:0] act3_ff;
   logic [MAG_W-1:0]        opa3_ff;
   logic [MAG_W-1:0]        opb3_ff;

   always_comb begin
      y_sum = DY_W'(base2_ff) + q2_ff;
      y_low = (kind_ff[2] == KIND_TANH) ? -ONE_DY : '0;
      if (y_sum > ONE_DY) begin
         y_clip = ONE_DY;
      end else if (y_sum < y_low) begin
         y_clip = y_low;
      end else begin
         y_clip = y_sum;
      end
      y_mag  = y_clip[DY_W-1] ? -y_clip : y_clip;
      y_rest = ONE_DY - y_clip;
      if (kind_ff[2] == KIND_TANH) begin
         opa3_in = y_mag[MAG_W-1:0];
         opb3_in = y_mag[MAG_W-1:0];
      end else begin
         opa3_in = y_clip[MAG_W-1:0];
         opb3_in = y_rest[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         act3_ff <= y_clip[TAB_W-1:0];
         opa3_ff <= opa3_in;
         opb3_ff <= opb3_in;
      end
   end

   // stage 4: derivative product
   logic signed [TAB_W-1:0] act4_ff;
   logic [PROD_W-1:0]       prod4_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         act4_ff  <= act3_ff;
         prod4_ff <= opa3_ff * opb3_ff;
      end
   end

   // stage 5: select by kind, saturate
   logic [PROD_W:0]        prod_rnd;
   logic [MAG_W-1:0]       prod_q;
   logic                   z_pos;
   logic [MAG_W-1:0]       der;
   logic [DW-1:0]          der_w;
   logic signed [AW-1:0]   act_w;
   logic signed [ACT_W-1:0] act5_in;
   logic [SLOPE_W-1:0]     slope5_in;
   logic signed [ACT_W-1:0] act5_ff;
   logic [SLOPE_W-1:0]     slope5_ff;

   assign prod_rnd = {1'b0, prod4_ff} + HALF_P;
   assign prod_q   = prod_rnd[FRACTION_BITS +: MAG_W];
   assign z_pos    = !z_ff[STAGES-2][IN_W-1] && (z_ff[STAGES-2] != '0);

   always_comb begin
      case (kind_ff[STAGES-2])
         KIND_RELU: begin
            act_w = z_pos ? AW'(z_ff[STAGES-2]) : '0;
            der   = z_pos ? MAG_W'(ONE_F) : '0;
         end
         KIND_SIGMOID: begin
            act_w = AW'(act4_ff);
            der   = prod_q;
         end
         KIND_TANH: begin
            act_w = AW'(act4_ff);
            der   = MAG_W'(ONE_F) - prod_q;
         end
         default: begin
            act_w = '0;
            der   = '0;
         end
      endcase
      if (act_w > AW'(ACT_MAX)) begin
         act5_in = ACT_W'(ACT_MAX);
      end else if (act_w < AW'(ACT_MIN)) begin
         act5_in = ACT_W'(ACT_MIN);
      end else begin
         act5_in = act_w[ACT_W-1:0];
      end
      der_w = DW'(der);
      if (der_w > DW'(SLOPE_MAX)) begin
         slope5_in = SLOPE_W'(SLOPE_MAX);
      end else begin
         slope5_in = der_w[SLOPE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         act5_ff   <= act5_in;
         slope5_ff <= slope5_in;
      end
   end

   assign act_out   = act5_ff;
   assign slope_out = slope5_ff;

endmodule

/* design/activation_with_derivative.sv */
// Top level: activation with derivative (ReLU, sigmoid, tanh), pipelined
//
//   channel    dir  contents
//   req_chan   in   valid/ready, pre_activation  s16 Q3.12
//   rsp_chan   out  valid/ready, activated s16 Q3.12, slope u13 Q1.12
//   csr_*      in   write enable, activation kind (0 ReLU, 1 sigmoid, 2 tanh)
//
// Six register stages: one item per cycle while results are taken; an accepted item
// passes through stages 0 to 5 in order, and the result is valid from the last one.
// The two multipliers (interpolation, derivative) each sit in a stage of their own.
// Reset is synchronous: stage valids clear, kind returns to ReLU.
// A stage holds only while the one after it is full and held; bubbles close up,
// so req ready falls only when all six stages are full and the result is not taken.
module activation_with_derivative import awd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   awd_req_if.sink           req_chan,
   awd_rsp_if.source         rsp_chan,
   input  logic              csr_write_enable,
   input  logic [KIND_W-1:0] csr_write_data
);

   `include "activation_with_derivative_macros.svh"

   kind_type          kind_ff;
   kind_type          kind_in;
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   stage_ready;
   stage_ctrl_type    ctrl;
   logic              in_acc;
   logic              out_acc;

   assign kind_in = csr_write_enable ? kind_type'(csr_write_data) : kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RELU;
      end else begin
         kind_ff <= kind_in;
      end
   end

   always_comb begin
      stage_ready[STAGES] = rsp_chan.ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      ctrl.load = stage_ready[STAGES-1:0];
      valid_in[0] = stage_ready[0] ? req_chan.valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = stage_ready[0];
   assign rsp_chan.valid = valid_ff[STAGES-1];
   assign in_acc         = req_chan.valid && req_chan.ready;
   assign out_acc        = rsp_chan.valid && rsp_chan.ready;

   awd_datapath u_datapath (
      .clock     (clock),
      .ctrl      (ctrl),
      .z_in      (req_chan.pre_activation),
      .kind_in   (kind_ff),
      .act_out   (rsp_chan.activated),
      .slope_out (rsp_chan.slope)
   );

   `AWD_ASSERT_NEXT(a_item_count, clock, reset, 1'b1, $countones(valid_ff) == $past($countones(valid_ff)) + $past(in_acc) - $past(out_acc))
   `AWD_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_chan.ready, &valid_ff)
   `AWD_ASSERT_NOW(a_slope_bound, clock, reset, rsp_chan.valid, rsp_chan.slope <= SLOPE_W'(SLOPE_LIM))

endmodule
